@@ rtl/arf_pkg.sv @@
package arf_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = 32;
  localparam int FLAG_W      = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_ORDER = 2'd2;
  localparam logic [1:0] STS_INDEX = 2'd3;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] range_first;
    logic [ADDR_W-1:0] range_last;
    logic [FLAG_W-1:0] rule_flags;
    logic [IDX_W-1:0]  entry_index;
  } arf_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [FLAG_W-1:0] access_flags;
    logic [ADDR_W-1:0] entry_first;
    logic [ADDR_W-1:0] entry_last;
    logic [CNT_W-1:0]  entry_count;
    logic              table_is_default;
  } arf_out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_A_RD0, ST_A_PR0, ST_A_RD1, ST_A_PR1, ST_A_RD2, ST_A_PR2,
    ST_A_END, ST_S_RD, ST_S_CMP, ST_F_RD, ST_F_OUT, ST_DONE
  } arf_state_t;

  typedef enum logic [1:0] {EMIT_NONE, EMIT_OLD, EMIT_RULE, EMIT_TAIL} arf_emit_t;
  typedef enum logic [1:0] {RA_K, RA_MID, RA_LO} arf_rsel_t;

  typedef struct packed {
    logic       load;
    logic       lo_from_idx;
    logic       set_status;
    logic [1:0] status_val;
    arf_emit_t  emit;
    logic       hold_upd;
    logic       adv;
    logic       srch_step;
    logic       fetch;
    logic       commit;
    arf_rsel_t  ra_sel;
  } arf_cmd_t;

  typedef struct packed {
    logic bad_order;
    logic idx_ok;
    logic at_end;
    logic s_lt_first;
    logic s_le_next;
    logic tail;
    logic overflow;
    logic lo_lt_hi;
  } arf_stat_t;

endpackage

@@ rtl/arf_dp.sv @@
module arf_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  arf_pkg::arf_in_t in_item,
  input  arf_pkg::arf_cmd_t cmd,
  output arf_pkg::arf_stat_t stat,
  output arf_pkg::arf_out_t res
);
  import arf_pkg::*;

  // two banks: active one is read, rebuilt table goes to the other
  logic [ADDR_W-1:0] start_mem [2*TABLE_DEPTH];
  logic [FLAG_W-1:0] flag_mem  [2*TABLE_DEPTH];

  arf_in_t           req_r;
  logic [CNT_W-1:0]  k_r, m_r, count_r;
  logic [IDX_W-1:0]  lo_r, hi_r;
  logic [FLAG_W-1:0] holder_r, last_flag_r, f0_new_r, flag0_r;
  logic              bank_r, init_r;
  logic [1:0]        status_r;
  logic [FLAG_W-1:0] rflags_r;
  logic [ADDR_W-1:0] rfirst_r, rlast_r;

  logic [ADDR_W-1:0] sa_q, sb_q, sa, sb, next_addr, e_start;
  logic [FLAG_W-1:0] fa_q, fa, e_flag;
  logic [IDX_W-1:0]  ra_idx, mid, lo1;
  logic [IDX_W:0]    mid_sum;
  logic              keep, wr_en, mid_le, lo1_ok;

  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi_r} + {{IDX_W{1'b0}}, 1'b1};
  assign mid       = mid_sum[IDX_W:1];
  assign lo1       = lo_r + 1'b1;
  assign lo1_ok    = ({1'b0, lo_r} + 1'b1) < count_r;
  assign next_addr = req_r.range_last + 1'b1;

  always_comb begin
    unique case (cmd.ra_sel)
      RA_K:    ra_idx = k_r[IDX_W-1:0];
      RA_MID:  ra_idx = mid;
      RA_LO:   ra_idx = lo_r;
      default: ra_idx = lo_r;
    endcase
  end

  always_ff @(posedge clk) begin
    sa_q <= start_mem[{bank_r, ra_idx}];
    fa_q <= flag_mem[{bank_r, ra_idx}];
    sb_q <= start_mem[{bank_r, lo1}];
    if (wr_en) begin
      start_mem[{~bank_r, m_r[IDX_W-1:0]}] <= e_start;
      flag_mem[{~bank_r, m_r[IDX_W-1:0]}]  <= e_flag;
    end
  end

  // untouched table since reset reads as entry 0 = (0, 0)
  assign sa = init_r ? '0 : sa_q;
  assign fa = init_r ? '0 : fa_q;
  assign sb = init_r ? '0 : sb_q;

  always_comb begin
    unique case (cmd.emit)
      EMIT_OLD: begin
        e_start = sa;
        e_flag  = fa;
      end
      EMIT_RULE: begin
        e_start = req_r.range_first;
        e_flag  = req_r.rule_flags;
      end
      EMIT_TAIL: begin
        e_start = next_addr;
        e_flag  = holder_r;
      end
      default: begin
        e_start = sa;
        e_flag  = fa;
      end
    endcase
  end

  // drop an entry whose flags equal the previous kept one
  assign keep   = (cmd.emit != EMIT_NONE) && !((m_r != '0) && (e_flag == last_flag_r));
  assign wr_en  = keep && (m_r < CNT_W'(TABLE_DEPTH));
  assign mid_le = sa <= req_r.range_first;

  assign stat.bad_order  = in_item.range_first > in_item.range_last;
  assign stat.idx_ok     = {1'b0, in_item.entry_index} < count_r;
  assign stat.at_end     = k_r == count_r;
  assign stat.s_lt_first = sa < req_r.range_first;
  assign stat.s_le_next  = sa <= next_addr;
  assign stat.tail       = req_r.range_last != '1;
  assign stat.overflow   = m_r > CNT_W'(TABLE_DEPTH);
  assign stat.lo_lt_hi   = lo_r < hi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_r  <= 1'b0;
      init_r  <= 1'b1;
      count_r <= CNT_W'(1);
      flag0_r <= '0;
    end else if (cmd.commit) begin
      bank_r  <= ~bank_r;
      init_r  <= 1'b0;
      count_r <= m_r;
      flag0_r <= f0_new_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r    <= in_item;
      k_r      <= '0;
      m_r      <= '0;
      lo_r     <= cmd.lo_from_idx ? in_item.entry_index : '0;
      hi_r     <= IDX_W'(count_r - 1'b1);
      status_r <= cmd.status_val;
      rflags_r <= '0;
      rfirst_r <= '0;
      rlast_r  <= '0;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_val;
    end
    if (keep) begin
      m_r         <= m_r + 1'b1;
      last_flag_r <= e_flag;
      if (m_r == '0) begin
        f0_new_r <= e_flag;
      end
    end
    if (cmd.hold_upd) begin
      holder_r <= fa;
    end
    if (cmd.adv) begin
      k_r <= k_r + 1'b1;
    end
    if (cmd.srch_step) begin
      if (mid_le) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid - 1'b1;
      end
    end
    if (cmd.fetch) begin
      rflags_r <= fa;
      rfirst_r <= sa;
      rlast_r  <= lo1_ok ? sb - 1'b1 : '1;
    end
  end

  assign res.status           = status_r;
  assign res.access_flags     = rflags_r;
  assign res.entry_first      = rfirst_r;
  assign res.entry_last       = rlast_r;
  assign res.entry_count      = count_r;
  assign res.table_is_default = (count_r == CNT_W'(1)) && (flag0_r == '0);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= CNT_W'(TABLE_DEPTH)))
    else $error("entry count out of range");
  a_commit_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !stat.overflow)
    else $error("commit of an overflowing table");
  a_commit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> count_r == $past(m_r))
    else $error("count not taken from rebuild");

endmodule

@@ rtl/arf_ctrl.sv @@
module arf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         action,
  input  arf_pkg::arf_stat_t stat,
  output logic               busy,
  output logic               out_strobe,
  output arf_pkg::arf_cmd_t  cmd
);
  import arf_pkg::*;

  arf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          priority if (action == ACT_ADD) begin
            state_nxt = stat.bad_order ? ST_DONE : ST_A_RD0;
          end else if (action == ACT_LOOKUP) begin
            state_nxt = ST_S_RD;
          end else if (action == ACT_READ) begin
            state_nxt = stat.idx_ok ? ST_F_RD : ST_DONE;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_A_RD0: state_nxt = ST_A_PR0;
      ST_A_PR0: begin
        if (!stat.at_end && stat.s_lt_first) begin
          state_nxt = ST_A_RD0;
        end else begin
          state_nxt = ST_A_PR1;
        end
      end
      ST_A_RD1: state_nxt = ST_A_PR1;
      ST_A_PR1: begin
        priority if (!stat.tail || stat.at_end) begin
          state_nxt = ST_A_END;
        end else if (stat.s_le_next) begin
          state_nxt = ST_A_RD1;
        end else begin
          state_nxt = ST_A_PR2;
        end
      end
      ST_A_RD2: state_nxt = ST_A_PR2;
      ST_A_PR2: state_nxt = stat.at_end ? ST_A_END : ST_A_RD2;
      ST_A_END: state_nxt = ST_DONE;
      ST_S_RD:  state_nxt = stat.lo_lt_hi ? ST_S_CMP : ST_F_RD;
      ST_S_CMP: state_nxt = ST_S_RD;
      ST_F_RD:  state_nxt = ST_F_OUT;
      ST_F_OUT: state_nxt = ST_DONE;
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.emit   = EMIT_NONE;
    cmd.ra_sel = RA_K;
    out_strobe = 1'b0;
    busy       = state_r != ST_IDLE;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load        = 1'b1;
          cmd.lo_from_idx = action == ACT_READ;
          if (action == ACT_ADD && stat.bad_order) begin
            cmd.status_val = STS_ORDER;
          end else if (action == ACT_READ && !stat.idx_ok) begin
            cmd.status_val = STS_INDEX;
          end else begin
            cmd.status_val = STS_OK;
          end
        end
      end
      ST_A_PR0: begin
        if (!stat.at_end && stat.s_lt_first) begin
          cmd.emit     = EMIT_OLD;
          cmd.hold_upd = 1'b1;
          cmd.adv      = 1'b1;
        end else begin
          cmd.emit = EMIT_RULE;
        end
      end
      ST_A_PR1: begin
        if (stat.tail) begin
          if (stat.at_end) begin
            cmd.emit = EMIT_TAIL;
          end else if (stat.s_le_next) begin
            cmd.hold_upd = 1'b1;
            cmd.adv      = 1'b1;
          end else begin
            cmd.emit = EMIT_TAIL;
          end
        end
      end
      ST_A_PR2: begin
        if (!stat.at_end) begin
          cmd.emit = EMIT_OLD;
          cmd.adv  = 1'b1;
        end
      end
      ST_A_END: begin
        if (stat.overflow) begin
          cmd.set_status = 1'b1;
          cmd.status_val = STS_FULL;
        end else begin
          cmd.commit = 1'b1;
        end
      end
      ST_S_RD:  cmd.ra_sel = stat.lo_lt_hi ? RA_MID : RA_LO;
      ST_S_CMP: begin
        cmd.ra_sel    = RA_MID;
        cmd.srch_step = 1'b1;
      end
      ST_F_RD:  cmd.ra_sel = RA_LO;
      ST_F_OUT: begin
        cmd.ra_sel = RA_LO;
        cmd.fetch  = 1'b1;
      end
      ST_DONE:  out_strobe = 1'b1;
      default:  cmd.ra_sel = RA_K;
    endcase
  end

  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("result strobe longer than one cycle");
  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("request taken without going busy");
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe while idle");

endmodule

@@ rtl/address_range_access_filter.sv @@
// Address range access filter.
// Keeps a sorted table of (start address, flags) entries covering the full
// 32-bit address space; entry 0 starts at 0 and neighbors differ in flags.
// Request channel: drive in_item and pulse start while busy is low; the
//   request is taken on that edge and busy stays high until the result.
//   Actions: add rule (give [first,last] new flags), look up an address,
//   read one entry by index.
// Result channel: out_strobe is high for exactly one cycle with out_item;
//   the receiver cannot hold it off and must take it then.
// Lookup runs a binary search, each probe through the registered table
//   read; read entry fetches the indexed entry; a malformed rule, a bad
//   index or an unused action goes straight to the result; add rule
//   streams the table entry by entry into the spare bank while the new
//   canonical table is built.
// One request at a time; the next may be started the cycle after the strobe.
// Reset: table is a single entry (0, flags 0), count 1, no clearing pass.
// An overflowing or malformed rule leaves the table untouched.
module address_range_access_filter (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  arf_pkg::arf_in_t  in_item,
  output logic              out_strobe,
  output arf_pkg::arf_out_t out_item
);
  import arf_pkg::*;

  arf_cmd_t  cmd;
  arf_stat_t stat;

  // sequencing of add/lookup/read phases
  arf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .action     (in_item.action),
    .stat       (stat),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  // table banks, merge logic, search pointers, result registers
  arf_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_item),
    .cmd     (cmd),
    .stat    (stat),
    .res     (out_item)
  );

endmodule

@@ sim/address_range_access_filter_tb.sv @@
module address_range_access_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import arf_pkg::*;

  // action code 3 is unused by the block; it still returns a result
  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [ADDR_W-1:0] ADDR_MAX = '1;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  arf_in_t  in_item = '0;
  logic     out_strobe;
  arf_out_t out_item;

  address_range_access_filter dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  always #6 clk = ~clk;

  // Shadow copy of the breakpoint table.
  logic [ADDR_W-1:0] bp_start [TABLE_DEPTH];
  logic [FLAG_W-1:0] bp_flags [TABLE_DEPTH];
  int unsigned       bp_count;

  arf_out_t expected_q [$];
  int       errors = 0;
  int       idle_cycles = 0;
  int       n_sent = 0;
  int       n_results = 0;
  int       n_full = 0;
  int       n_order = 0;
  int       n_index = 0;
  int       max_count = 1;

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------

  // Entry whose range holds addr: last entry with start <= addr.
  function automatic int unsigned find_range(logic [ADDR_W-1:0] addr);
    int unsigned hit;
    hit = 0;
    for (int unsigned k = 1; k < bp_count; k++)
      if (bp_start[k] <= addr) hit = k;
    return hit;
  endfunction

  function automatic logic [ADDR_W-1:0] range_end(int unsigned k);
    if (k + 1 < bp_count) return bp_start[k+1] - 1'b1;
    return ADDR_MAX;
  endfunction

  // Rebuild the canonical table with [first,last] set to flags.
  function automatic logic [1:0] apply_rule(logic [ADDR_W-1:0] first,
                                            logic [ADDR_W-1:0] last,
                                            logic [FLAG_W-1:0] flags);
    logic [ADDR_W-1:0] ts [TABLE_DEPTH+2];
    logic [FLAG_W-1:0] tf [TABLE_DEPTH+2];
    logic [ADDR_W-1:0] nxt;
    int unsigned n, m;
    if (first > last) return STS_ORDER;
    n = 0;
    nxt = last + 1'b1;
    for (int unsigned k = 0; k < bp_count; k++)
      if (bp_start[k] < first) begin
        ts[n] = bp_start[k]; tf[n] = bp_flags[k]; n++;
      end
    ts[n] = first; tf[n] = flags; n++;
    if (last != ADDR_MAX) begin
      ts[n] = nxt; tf[n] = bp_flags[find_range(nxt)]; n++;
      for (int unsigned k = 0; k < bp_count; k++)
        if (bp_start[k] > nxt) begin
          ts[n] = bp_start[k]; tf[n] = bp_flags[k]; n++;
        end
    end
    // merge neighbors with equal flags
    m = 1;
    for (int unsigned k = 1; k < n; k++)
      if (tf[k] != tf[m-1]) begin
        ts[m] = ts[k]; tf[m] = tf[k]; m++;
      end
    if (m > TABLE_DEPTH) return STS_FULL;
    for (int unsigned k = 0; k < TABLE_DEPTH; k++) begin
      bp_start[k] = (k < m) ? ts[k] : '0;
      bp_flags[k] = (k < m) ? tf[k] : '0;
    end
    bp_count = m;
    return STS_OK;
  endfunction

  // Expected result of one request; updates the shadow table.
  function automatic arf_out_t filter_predict(arf_in_t req);
    arf_out_t    r;
    int unsigned k;
    r = '0;
    case (req.action)
      ACT_ADD: r.status = apply_rule(req.range_first, req.range_last, req.rule_flags);
      ACT_LOOKUP: begin
        k = find_range(req.range_first);
        r.access_flags = bp_flags[k];
        r.entry_first  = bp_start[k];
        r.entry_last   = range_end(k);
      end
      ACT_READ: begin
        if (req.entry_index < bp_count) begin
          r.access_flags = bp_flags[req.entry_index];
          r.entry_first  = bp_start[req.entry_index];
          r.entry_last   = range_end(req.entry_index);
        end else begin
          r.status = STS_INDEX;
        end
      end
      default: ;
    endcase
    r.entry_count      = bp_count[CNT_W-1:0];
    r.table_is_default = (bp_count == 1 && bp_flags[0] == '0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Request driver: drive at falling edge, take acceptance at rising edge.
  // start is left high after acceptance so back-to-back requests never
  // lower and raise it in one step; take_break lowers it.
  // --------------------------------------------------------------------------
  task automatic send_request(arf_in_t req);
    arf_out_t r;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    r = filter_predict(req);
    expected_q = {expected_q, r};
    n_sent++;
    if (r.status == STS_FULL) n_full++;
    if (r.status == STS_ORDER) n_order++;
    if (r.status == STS_INDEX) n_index++;
    if (bp_count > max_count) max_count = bp_count;
  endtask

  task automatic take_break(int unsigned cycles);
    @(negedge clk);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // end of a random burst: sometimes a gap, sometimes none
  int burst_left = 0;
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) take_break($urandom_range(0, 9));
    end
    burst_left--;
  endtask

  function automatic arf_in_t make_req(logic [1:0] act, logic [ADDR_W-1:0] first,
                                       logic [ADDR_W-1:0] last, logic [FLAG_W-1:0] flags,
                                       logic [IDX_W-1:0] idx);
    arf_in_t q;
    q.action = act; q.range_first = first; q.range_last = last;
    q.rule_flags = flags; q.entry_index = idx;
    return q;
  endfunction

  // Address near an existing breakpoint, to hit range edges.
  function automatic logic [ADDR_W-1:0] near_edge();
    logic [ADDR_W-1:0] base;
    base = bp_start[$urandom_range(0, bp_count - 1)];
    case ($urandom_range(0, 2))
      0: return base;
      1: return base - 1'b1;
      default: return base + $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 255);
      2: return ADDR_MAX - $urandom_range(0, 255);
      default: return near_edge();
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result checker
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t mismatch %s: got %h, expected %h", $realtime, what, got, want);
  endtask

  always @(posedge clk) begin
    arf_out_t want;
    if (rst_n && out_strobe) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("result count", longint'(n_results), longint'(n_sent));
      end else begin
        want = expected_q.pop_front();
        if (out_item.status !== want.status)
          report_mismatch("status", longint'(out_item.status), longint'(want.status));
        if (out_item.access_flags !== want.access_flags)
          report_mismatch("access_flags", longint'(out_item.access_flags),
                          longint'(want.access_flags));
        if (out_item.entry_first !== want.entry_first)
          report_mismatch("entry_first", longint'(out_item.entry_first),
                          longint'(want.entry_first));
        if (out_item.entry_last !== want.entry_last)
          report_mismatch("entry_last", longint'(out_item.entry_last),
                          longint'(want.entry_last));
        if (out_item.entry_count !== want.entry_count)
          report_mismatch("entry_count", longint'(out_item.entry_count),
                          longint'(want.entry_count));
        if (out_item.table_is_default !== want.table_is_default)
          report_mismatch("table_is_default", longint'(out_item.table_is_default),
                          longint'(want.table_is_default));
      end
    end
  end

  // Watchdog: cycles with neither an accepted request nor a result.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired, %0d results outstanding", expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Field extremes, each action, and the special cases.
  task automatic test_directed();
    send_request(make_req(ACT_NONE, '1, '1, '1, '1));
    send_request(make_req(ACT_LOOKUP, '0, '0, '0, '0));
    send_request(make_req(ACT_LOOKUP, ADDR_MAX, '0, '0, '0));
    send_request(make_req(ACT_READ, '0, '0, '0, '0));
    send_request(make_req(ACT_READ, '0, '0, '0, 6'd1));  // beyond count
    send_request(make_req(ACT_ADD, 32'd5, 32'd4, 32'h1, '0)); // first above last
    send_request(make_req(ACT_ADD, ADDR_MAX, '0, '1, '0));
    send_request(make_req(ACT_ADD, 32'hFFFF_FFF0, ADDR_MAX, '1, '0)); // no tail
    send_request(make_req(ACT_ADD, '0, '0, 32'h1, '0));   // single address at 0
    send_request(make_req(ACT_ADD, 32'h8000_0000, 32'h8000_0000, 32'h5A5A_A5A5, '0));
    send_request(make_req(ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0001, 32'h5A5A_A5A5, '0));
    send_request(make_req(ACT_ADD, 32'd1, 32'd9, 32'h1, '0)); // merge with entry 0
    for (int i = 0; i < 5; i++)
      send_request(make_req(ACT_READ, '0, '0, '0, i[IDX_W-1:0]));
    send_request(make_req(ACT_READ, '0, '0, '0, '1));
    send_request(make_req(ACT_LOOKUP, 32'h8000_0001, '0, '0, '0));
    send_request(make_req(ACT_LOOKUP, 32'hFFFF_FFEF, '0, '0, '0));
    send_request(make_req(ACT_ADD, '0, ADDR_MAX, '0, '0));    // back to default
    send_request(make_req(ACT_ADD, 32'd100, 32'd200, '0, '0)); // no change
    send_request(make_req(ACT_LOOKUP, 32'd150, '0, '0, '0));
    take_break(3);
  endtask

  // Fill the table to its depth exactly, then overflow it.
  task automatic test_table_full();
    logic [ADDR_W-1:0] base;
    send_request(make_req(ACT_ADD, '0, ADDR_MAX, '0, '0));
    for (int i = 0; i < 33; i++) begin
      base = i * 1000;
      send_request(make_req(ACT_ADD, base, base + 10, i + 1, '0));
    end
    send_request(make_req(ACT_ADD, 32'd50000, 32'd50000, 32'hAB, '0));
    send_request(make_req(ACT_READ, '0, '0, '0, 6'd63));
    send_request(make_req(ACT_LOOKUP, 32'd31005, '0, '0, '0));
    send_request(make_req(ACT_LOOKUP, ADDR_MAX, '0, '0, '0));
    // overwrite the filled area from address 5 up; shrinks the table again
    send_request(make_req(ACT_ADD, 32'd5, 32'd32005, 32'h77, '0));
    take_break(2);
  endtask

  // Random mix: rules with few flag values so ranges merge, lookups aimed at
  // edges, reads mostly of existing entries, some malformed rules and unused actions.
  task automatic test_random(int unsigned items);
    arf_in_t q;
    logic [ADDR_W-1:0] a, b;
    int unsigned sel;
    for (int unsigned i = 0; i < items; i++) begin
      pace();
      sel = $urandom_range(0, 99);
      q = make_req(ACT_NONE, $urandom(), $urandom(), $urandom(), IDX_W'($urandom()));
      if (sel < 40) begin
        q.action = ACT_ADD;
        a = rand_addr();
        b = ($urandom_range(0, 3) == 0) ? rand_addr() : a + $urandom_range(0, 300);
        if (b < a && $urandom_range(0, 4) != 0) begin
          q.range_first = b; q.range_last = a;
        end else begin
          q.range_first = a; q.range_last = b;
        end
        if ($urandom_range(0, 3) != 0) q.rule_flags = $urandom_range(0, 3);
        // keep the table from sitting at full most of the time
        if (bp_count > 50 && $urandom_range(0, 3) == 0) begin
          q.range_first = '0; q.range_last = ADDR_MAX; q.rule_flags = $urandom_range(0, 1);
        end
      end else if (sel < 75) begin
        q.action = ACT_LOOKUP;
        q.range_first = rand_addr();
      end else if (sel < 97) begin
        q.action = ACT_READ;
        if ($urandom_range(0, 3) != 0)
          q.entry_index = IDX_W'($urandom_range(0, bp_count - 1));
      end
      send_request(q);
    end
    take_break(1);
  endtask

  initial begin
    bp_start = '{default: '0};
    bp_flags = '{default: '0};
    bp_count = 1;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_table_full();
    test_random(1350);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("Sent %0d requests, checked %0d results; peak table size %0d.",
             n_sent, n_results, max_count);
    $display("Rejected: %0d table full, %0d first above last, %0d bad index.",
             n_full, n_order, n_index);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
